// ===== hdl/bspa_pkg.sv =====
// ----------------------------------------------------------------------------
// bspa_pkg
// Shared types, codes and widths for the bitmap slot pool allocator.
// ----------------------------------------------------------------------------
package bspa_pkg;

    // Default build capacity in slots
    localparam int DEF_POOL_SLOTS = 64;

    // Field widths
    localparam int ADDR_W     = 32;
    localparam int SB_W       = 13;
    localparam int SIU_W      = 7;
    localparam int POL_W      = 2;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int IDX_OUT_W  = 6;
    localparam int CNT_OUT_W  = 7;
    localparam int CTR_W      = 32;

    // Bitmap words: eight busy bits per RAM word
    localparam int WORD_BITS  = 8;
    localparam int WBIT_W     = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Stream payload widths
    localparam int S_TDATA_W  = ADDR_W;
    localparam int S_TUSER_W  = CMD_W + 1;
    localparam int M_PAYLOAD_W = IDX_OUT_W + ADDR_W + 2 * CNT_OUT_W + 4 * CTR_W;
    localparam int M_TDATA_W  = ((M_PAYLOAD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = M_TDATA_W - M_PAYLOAD_W;
    localparam int M_TUSER_W  = STATUS_W;

    // Register reset values
    localparam logic [ADDR_W-1:0] BASE_RESET = '0;
    localparam logic [SB_W-1:0]   SB_RESET   = 13'd32;
    localparam logic [SIU_W-1:0]  SIU_RESET  = 7'd64;
    localparam logic [POL_W-1:0]  POL_RESET  = 2'd0;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_BYTES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY       = 2'd3;

    // Commands
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STATS = 2'd2;

    // Overflow policies
    localparam logic [POL_W-1:0] POL_DROP     = 2'd0;
    localparam logic [POL_W-1:0] POL_TRAP     = 2'd1;
    localparam logic [POL_W-1:0] POL_FALLBACK = 2'd2;
    localparam logic [POL_W-1:0] POL_RESERVED = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_DROP     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_TRAP     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FALLBACK = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_RANGE    = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_ALIGN    = 3'd5;

    // Sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_ALLOC_ADDR,
        S_FREE_CHK,
        S_FREE_DIV,
        S_FREE_RD,
        S_FREE_WR,
        S_RESP
    } state_t;

endpackage

// ===== hdl/bspa_ram.sv =====
// ----------------------------------------------------------------------------
// bspa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bspa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk) begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/bitmap_slot_pool_allocator_core.sv =====
// Allocate: bitmap words are scanned in turn (8 slots a word, up to ceil(n/8) words, at least one),
//   each read in S_ALLOC_RD and checked in S_ALLOC_CHK; a hit goes on to S_ALLOC_ADDR.
// Free: range check, one quotient bit per cycle from the shared compare/subtract divider, then
//   bitmap read and write (a reject ends early); stats reset and unknown commands go straight to S_RESP.
// One beat in work at a time; s_tready is raised again in the cycle after the result is registered.
// Reset (aresetn low, synchronous) starts a clearing pass over all ceil(POOL_SLOTS/8) bitmap words.
// ----------------------------------------------------------------------------
// bitmap_slot_pool_allocator_core
// Fixed-size slot allocator: bitmap scan for alloc, range/alignment check and
// iterative division for free, plus usage statistics.
// ----------------------------------------------------------------------------
module bitmap_slot_pool_allocator_core
    import bspa_pkg::*;
#(
    parameter int POOL_SLOTS = DEF_POOL_SLOTS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] release_address
    input  logic [S_TUSER_W-1:0]  s_tuser,   // [1:0] command, [2] from_interrupt
    // result beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [5:0] slot_index, [37:6] slot_address,
                                             // [44:38] free_count, [51:45] peak_count,
                                             // [83:52] attempt_total, [115:84] failure_total,
                                             // [147:116] success_total,
                                             // [179:148] release_total, [183:180] zero
    output logic [M_TUSER_W-1:0]  m_tuser,   // [2:0] status
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH  = (POOL_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CNT_W  = $clog2(POOL_SLOTS + 1);
    localparam int SPAN_W = CNT_W + SB_W;
    localparam int STEP_W = (IDX_W > 1) ? $clog2(IDX_W) : 1;
    localparam int SLOT_W = AW + WBIT_W;

    // Sequencer and work registers
    state_t                state_reg, state_next;
    logic [AW-1:0]         word_reg, word_next;
    logic                  isr_reg, isr_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [SPAN_W-1:0]     span_reg, span_next;
    logic [SPAN_W-1:0]     rem_reg, rem_next;
    logic [SPAN_W-1:0]     div_reg, div_next;
    logic [IDX_W-1:0]      quo_reg, quo_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [WBIT_W-1:0]     bit_reg, bit_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [ADDR_W-1:0]     saddr_reg, saddr_next;

    // Configuration registers
    logic [ADDR_W-1:0]     base_reg, base_next;
    logic [SB_W-1:0]       sb_reg, sb_next;
    logic [SIU_W-1:0]      siu_reg, siu_next;
    logic [POL_W-1:0]      pol_reg, pol_next;

    // Statistics
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]      peak_reg, peak_next;
    logic [CTR_W-1:0]      att_reg, att_next;
    logic [CTR_W-1:0]      fail_reg, fail_next;
    logic [CTR_W-1:0]      succ_reg, succ_next;
    logic [CTR_W-1:0]      rel_reg, rel_next;

    // Output register
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0]  m_tuser_reg, m_tuser_next;

    // Bitmap RAM
    logic                  ram_we;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [WORD_BITS-1:0]  ram_rdata;

    // Datapath helpers
    logic [CNT_W-1:0]      n_w;
    logic [WORD_BITS-1:0]  avail;
    logic                  hit;
    logic [WBIT_W-1:0]     hit_bit;
    logic [SLOT_W-1:0]     hit_slot;
    logic [31:0]           next_start;
    logic [STATUS_W-1:0]   fail_status;
    logic [ADDR_W-1:0]     offset;
    logic                  div_ge;
    logic [SPAN_W-1:0]     rem_sub;
    logic [IDX_W:0]        quo_shift;
    logic [SLOT_W-1:0]     quo_slot;
    logic [31:0]           free_wide;
    logic [31:0]           peak_wide;
    logic [31:0]           idx_wide;
    logic [31:0]           prod;

    bspa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_bitmap (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (word_reg),
        .wdata (ram_wdata),
        .raddr (word_reg),
        .rdata (ram_rdata)
    );

    // Managed slot count, clamped to the built capacity
    assign n_w = (32'(siu_reg) > 32'(POOL_SLOTS)) ? CNT_W'(POOL_SLOTS) : CNT_W'(siu_reg);

    // Free slots in the current word, lowest one wins
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            avail[b] = !ram_rdata[b] &&
                       (32'({word_reg, WBIT_W'(b)}) < 32'(n_w));
        end
        hit     = 1'b0;
        hit_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (avail[b]) begin
                hit     = 1'b1;
                hit_bit = WBIT_W'(b);
            end
        end
    end

    assign hit_slot   = {word_reg, hit_bit};
    assign next_start = (32'(word_reg) + 32'd1) << WBIT_W;

    // Status of an exhausted allocate
    always_comb begin
        if (isr_reg || (pol_reg inside {POL_DROP, POL_RESERVED})) begin
            fail_status = STAT_DROP;
        end else if (pol_reg == POL_TRAP) begin
            fail_status = STAT_TRAP;
        end else begin
            fail_status = STAT_FALLBACK;
        end
    end

    // Shared compare/subtract step of the divider
    assign offset    = addr_reg - base_reg;
    assign div_ge    = rem_reg >= div_reg;
    assign rem_sub   = div_ge ? (rem_reg - div_reg) : rem_reg;
    assign quo_shift = {quo_reg, div_ge};
    assign quo_slot  = SLOT_W'(quo_shift[IDX_W-1:0]);

    // Slot address multiply, registered in the next state
    assign prod = 32'(idx_reg) * 32'(sb_reg);

    // Result fields
    assign free_wide = (32'(n_w) > 32'(cnt_reg)) ? (32'(n_w) - 32'(cnt_reg)) : 32'd0;
    assign peak_wide = 32'(peak_reg);
    assign idx_wide  = 32'(idx_reg);

    // Next state and datapath
    always_comb begin
        state_next    = state_reg;
        word_next     = word_reg;
        isr_next      = isr_reg;
        addr_next     = addr_reg;
        span_next     = span_reg;
        rem_next      = rem_reg;
        div_next      = div_reg;
        quo_next      = quo_reg;
        step_next     = step_reg;
        idx_next      = idx_reg;
        bit_next      = bit_reg;
        status_next   = status_reg;
        saddr_next    = saddr_reg;
        base_next     = base_reg;
        sb_next       = sb_reg;
        siu_next      = siu_reg;
        pol_next      = pol_reg;
        cnt_next      = cnt_reg;
        peak_next     = peak_reg;
        att_next      = att_reg;
        fail_next     = fail_reg;
        succ_next     = succ_reg;
        rel_next      = rel_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        ram_we        = 1'b0;
        ram_wdata     = '0;
        s_tready      = 1'b0;

        // result register drains independently
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // configuration writes are taken in any state
        if (cfg_valid) begin
            case (cfg_index)
                REG_BASE:         base_next = cfg_data[ADDR_W-1:0];
                REG_SLOT_BYTES:   sb_next   = cfg_data[SB_W-1:0];
                REG_SLOTS_IN_USE: siu_next  = cfg_data[SIU_W-1:0];
                REG_POLICY:       pol_next  = cfg_data[POL_W-1:0];
                default:          ;
            endcase
        end

        case (state_reg)
            // zero the bitmap, one word a cycle
            S_CLEAR: begin
                ram_we = 1'b1;
                if (word_reg == AW'(DEPTH - 1)) begin
                    word_next  = '0;
                    state_next = S_IDLE;
                end else begin
                    word_next = word_reg + AW'(1);
                end
            end

            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    isr_next    = s_tuser[CMD_W];
                    addr_next   = s_tdata[ADDR_W-1:0];
                    span_next   = SPAN_W'(n_w) * SPAN_W'(sb_reg);
                    status_next = STAT_OK;
                    idx_next    = '0;
                    saddr_next  = '0;
                    word_next   = '0;
                    case (s_tuser[CMD_W-1:0])
                        CMD_ALLOC: begin
                            att_next   = att_reg + CTR_W'(1);
                            state_next = S_ALLOC_RD;
                        end
                        CMD_FREE: begin
                            state_next = S_FREE_CHK;
                        end
                        CMD_STATS: begin
                            att_next   = '0;
                            fail_next  = '0;
                            succ_next  = '0;
                            rel_next   = '0;
                            peak_next  = cnt_reg;
                            state_next = S_RESP;
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            // wait for the bitmap word
            S_ALLOC_RD: begin
                state_next = S_ALLOC_CHK;
            end

            S_ALLOC_CHK: begin
                if (hit) begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata | (WORD_BITS'(1) << hit_bit);
                    idx_next   = IDX_W'(hit_slot);
                    state_next = S_ALLOC_ADDR;
                end else if (next_start >= 32'(n_w)) begin
                    fail_next   = fail_reg + CTR_W'(1);
                    status_next = fail_status;
                    state_next  = S_RESP;
                end else begin
                    word_next  = word_reg + AW'(1);
                    state_next = S_ALLOC_RD;
                end
            end

            S_ALLOC_ADDR: begin
                saddr_next = base_reg + prod;
                succ_next  = succ_reg + CTR_W'(1);
                cnt_next   = cnt_reg + CNT_W'(1);
                if ((cnt_reg + CNT_W'(1)) > peak_reg) begin
                    peak_next = cnt_reg + CNT_W'(1);
                end
                state_next = S_RESP;
            end

            // range check, then set up the divider
            S_FREE_CHK: begin
                if ((addr_reg < base_reg) || (offset >= 32'(span_reg))) begin
                    status_next = STAT_RANGE;
                    state_next  = S_RESP;
                end else begin
                    rem_next   = SPAN_W'(offset);
                    div_next   = SPAN_W'(sb_reg) << (IDX_W - 1);
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = S_FREE_DIV;
                end
            end

            // one quotient bit per cycle
            S_FREE_DIV: begin
                rem_next  = rem_sub;
                div_next  = div_reg >> 1;
                quo_next  = quo_shift[IDX_W-1:0];
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(IDX_W - 1)) begin
                    if (rem_sub != '0) begin
                        status_next = STAT_ALIGN;
                        state_next  = S_RESP;
                    end else begin
                        idx_next   = quo_shift[IDX_W-1:0];
                        word_next  = quo_slot[SLOT_W-1:WBIT_W];
                        bit_next   = quo_slot[WBIT_W-1:0];
                        state_next = S_FREE_RD;
                    end
                end
            end

            S_FREE_RD: begin
                state_next = S_FREE_WR;
            end

            S_FREE_WR: begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata & ~(WORD_BITS'(1) << bit_reg);
                saddr_next = addr_reg;
                rel_next   = rel_reg + CTR_W'(1);
                if (cnt_reg != '0) begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                state_next = S_RESP;
            end

            // hand the result to the output register when it is free
            S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status_reg;
                    m_tdata_next  = {{OUT_PAD_W{1'b0}}, rel_reg, succ_reg, fail_reg, att_reg,
                                     peak_wide[CNT_OUT_W-1:0], free_wide[CNT_OUT_W-1:0],
                                     saddr_reg, idx_wide[IDX_OUT_W-1:0]};
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            word_reg     <= '0;
            base_reg     <= BASE_RESET;
            sb_reg       <= SB_RESET;
            siu_reg      <= SIU_RESET;
            pol_reg      <= POL_RESET;
            cnt_reg      <= '0;
            peak_reg     <= '0;
            att_reg      <= '0;
            fail_reg     <= '0;
            succ_reg     <= '0;
            rel_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            word_reg     <= word_next;
            base_reg     <= base_next;
            sb_reg       <= sb_next;
            siu_reg      <= siu_next;
            pol_reg      <= pol_next;
            cnt_reg      <= cnt_next;
            peak_reg     <= peak_next;
            att_reg      <= att_next;
            fail_reg     <= fail_next;
            succ_reg     <= succ_next;
            rel_reg      <= rel_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        isr_reg     <= isr_next;
        addr_reg    <= addr_next;
        span_reg    <= span_next;
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        quo_reg     <= quo_next;
        step_reg    <= step_next;
        idx_reg     <= idx_next;
        bit_reg     <= bit_next;
        status_reg  <= status_next;
        saddr_reg   <= saddr_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // register writes are taken in any state
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

endmodule

// ===== hdl/bspa_checker.sv =====
// ----------------------------------------------------------------------------
// bspa_props
// Port-level checks for the slot pool allocator core, bound to the core module.
// ----------------------------------------------------------------------------
module bspa_props
    import bspa_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // no result beat right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // one beat in work at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a beat is in work");

    // a failed request reports no slot
    a_fail_no_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STAT_OK) |-> m_tdata[IDX_OUT_W+ADDR_W-1:0] == '0)
        else $error("failed request carries a slot");

endmodule

bind bitmap_slot_pool_allocator_core bspa_props u_bspa_props (.*);

// ===== sim/bspa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspa_checker
// Watches the request, result and register channels of the slot pool
// allocator, keeps its own copy of the pool bitmap, registers and counters,
// and compares every result beat field by field with the predicted outcome.
// ----------------------------------------------------------------------------
module bspa_checker
    import bspa_pkg::*;
#(
    parameter int POOL_SLOTS = DEF_POOL_SLOTS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] release_address
    input  logic [S_TUSER_W-1:0]  s_tuser,   // [1:0] command, [2] from_interrupt
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // slot_index, slot_address, free_count,
                                             // peak_count, four totals, pad
    input  logic [M_TUSER_W-1:0]  m_tuser,   // [2:0] status
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    error_count,
    output int                    outstanding
);

    // Result payload bit offsets
    localparam int P_ADDR = IDX_OUT_W;
    localparam int P_FREE = P_ADDR + ADDR_W;
    localparam int P_PEAK = P_FREE + CNT_OUT_W;
    localparam int P_ATT  = P_PEAK + CNT_OUT_W;
    localparam int P_FAIL = P_ATT + CTR_W;
    localparam int P_SUCC = P_FAIL + CTR_W;
    localparam int P_REL  = P_SUCC + CTR_W;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [IDX_OUT_W-1:0] slot;
        logic [ADDR_W-1:0]    addr;
        logic [CNT_OUT_W-1:0] free_slots;
        logic [CNT_OUT_W-1:0] peak;
        logic [CTR_W-1:0]     attempts;
        logic [CTR_W-1:0]     failures;
        logic [CTR_W-1:0]     successes;
        logic [CTR_W-1:0]     releases;
    } pool_outcome_t;

    // Shadow registers and pool state
    logic [ADDR_W-1:0] reg_base;
    logic [SB_W-1:0]   reg_slot_bytes;
    logic [SIU_W-1:0]  reg_slots;
    logic [POL_W-1:0]  reg_policy;
    logic              pool_busy [POOL_SLOTS];
    int unsigned       live_count;
    int unsigned       peak_live;
    logic [CTR_W-1:0]  cnt_attempt;
    logic [CTR_W-1:0]  cnt_fail;
    logic [CTR_W-1:0]  cnt_success;
    logic [CTR_W-1:0]  cnt_release;

    pool_outcome_t expected_outcomes [$];
    pool_outcome_t predicted;
    pool_outcome_t observed;
    pool_outcome_t oldest;
    int            mismatch_total = 0;
    int            result_seq = 0;
    int            push_n;
    int            pop_n;

    assign error_count = mismatch_total;

    task report_mismatch(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("[%0t] result %0d mismatch on %s: got 0x%0h, want 0x%0h",
                 $realtime, result_seq, field, got, want);
        mismatch_total++;
    endtask

    task reset_pool_model();
        reg_base       = BASE_RESET;
        reg_slot_bytes = SB_RESET;
        reg_slots      = SIU_RESET;
        reg_policy     = POL_RESET;
        for (int i = 0; i < POOL_SLOTS; i++) pool_busy[i] = 1'b0;
        live_count  = 0;
        peak_live   = 0;
        cnt_attempt = '0;
        cnt_fail    = '0;
        cnt_success = '0;
        cnt_release = '0;
    endtask

    // Outcome of one request; updates the shadow pool
    task automatic model_pool_request(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                                      input logic irq, output pool_outcome_t o);
        int unsigned     n;
        int              slot;
        longint unsigned span;
        longint unsigned off;
        longint unsigned sum;
        o = '0;
        n = (reg_slots > POOL_SLOTS) ? POOL_SLOTS : reg_slots;
        if (cmd == CMD_ALLOC) begin
            slot = -1;
            for (int i = 0; i < n; i++) begin
                if (slot < 0 && !pool_busy[i]) slot = i;
            end
            cnt_attempt++;
            if (slot < 0) begin
                cnt_fail++;
                if (irq || reg_policy == POL_DROP || reg_policy == POL_RESERVED)
                    o.status = STAT_DROP;
                else if (reg_policy == POL_TRAP)
                    o.status = STAT_TRAP;
                else
                    o.status = STAT_FALLBACK;
            end else begin
                pool_busy[slot] = 1'b1;
                sum = longint'(reg_base) + longint'(slot) * longint'(reg_slot_bytes);
                o.slot = slot[IDX_OUT_W-1:0];
                o.addr = sum[ADDR_W-1:0];
                cnt_success++;
                live_count++;
                if (live_count > peak_live) peak_live = live_count;
            end
        end else if (cmd == CMD_FREE) begin
            span = longint'(n) * longint'(reg_slot_bytes);
            if (addr < reg_base || longint'(addr) - longint'(reg_base) >= span) begin
                o.status = STAT_RANGE;
            end else begin
                // span is nonzero here, so the slot size is too
                off = longint'(addr) - longint'(reg_base);
                if (off % reg_slot_bytes != 0) begin
                    o.status = STAT_ALIGN;
                end else begin
                    slot = int'(off / reg_slot_bytes);
                    pool_busy[slot] = 1'b0;
                    o.slot = slot[IDX_OUT_W-1:0];
                    o.addr = addr;
                    cnt_release++;
                    if (live_count > 0) live_count--;
                end
            end
        end else if (cmd == CMD_STATS) begin
            cnt_attempt = '0;
            cnt_fail    = '0;
            cnt_success = '0;
            cnt_release = '0;
            peak_live   = live_count;
        end
        o.free_slots = (n > live_count) ? CNT_OUT_W'(n - live_count) : '0;
        o.peak       = CNT_OUT_W'(peak_live);
        o.attempts   = cnt_attempt;
        o.failures   = cnt_fail;
        o.successes  = cnt_success;
        o.releases   = cnt_release;
    endtask

    // Sample all three channels at the clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_pool_model();
            expected_outcomes.delete();
            outstanding <= 0;
        end else begin
            push_n = 0;
            pop_n  = 0;

            // result beat against the oldest prediction
            if (m_tvalid && m_tready) begin
                observed.status     = m_tuser[STATUS_W-1:0];
                observed.slot       = m_tdata[IDX_OUT_W-1:0];
                observed.addr       = m_tdata[P_ADDR +: ADDR_W];
                observed.free_slots = m_tdata[P_FREE +: CNT_OUT_W];
                observed.peak       = m_tdata[P_PEAK +: CNT_OUT_W];
                observed.attempts   = m_tdata[P_ATT +: CTR_W];
                observed.failures   = m_tdata[P_FAIL +: CTR_W];
                observed.successes  = m_tdata[P_SUCC +: CTR_W];
                observed.releases   = m_tdata[P_REL +: CTR_W];
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("unrequested result", observed.status, '0);
                end else begin
                    oldest = expected_outcomes.pop_front();
                    pop_n  = 1;
                    if (observed.status != oldest.status)
                        report_mismatch("status", observed.status, oldest.status);
                    if (observed.slot != oldest.slot)
                        report_mismatch("slot_index", observed.slot, oldest.slot);
                    if (observed.addr != oldest.addr)
                        report_mismatch("slot_address", observed.addr, oldest.addr);
                    if (observed.free_slots != oldest.free_slots)
                        report_mismatch("free_count", observed.free_slots, oldest.free_slots);
                    if (observed.peak != oldest.peak)
                        report_mismatch("peak_count", observed.peak, oldest.peak);
                    if (observed.attempts != oldest.attempts)
                        report_mismatch("attempt_total", observed.attempts, oldest.attempts);
                    if (observed.failures != oldest.failures)
                        report_mismatch("failure_total", observed.failures, oldest.failures);
                    if (observed.successes != oldest.successes)
                        report_mismatch("success_total", observed.successes, oldest.successes);
                    if (observed.releases != oldest.releases)
                        report_mismatch("release_total", observed.releases, oldest.releases);
                end
                result_seq++;
            end

            // register write
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BASE:         reg_base       = cfg_data[ADDR_W-1:0];
                    REG_SLOT_BYTES:   reg_slot_bytes = cfg_data[SB_W-1:0];
                    REG_SLOTS_IN_USE: reg_slots      = cfg_data[SIU_W-1:0];
                    REG_POLICY:       reg_policy     = cfg_data[POL_W-1:0];
                    default: ;
                endcase
            end

            // request beat
            if (s_tvalid && s_tready) begin
                model_pool_request(s_tuser[CMD_W-1:0], s_tdata[ADDR_W-1:0], s_tuser[CMD_W],
                                   predicted);
                expected_outcomes.push_back(predicted);
                push_n = 1;
            end

            outstanding <= outstanding + push_n - pop_n;
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the slot pool allocator: a directed pass over exhaustion,
// policies, range and alignment rejects and odd register settings, then
// random alloc/free traffic over many register settings with random stalls
// on both stream sides. The checker does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top
    import bspa_pkg::*;
();

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1250;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count;
    int outstanding;

    // Current register settings, for building well-formed free addresses
    logic [ADDR_W-1:0] cur_base = BASE_RESET;
    logic [SB_W-1:0]   cur_sb   = SB_RESET;
    logic [SIU_W-1:0]  cur_siu  = SIU_RESET;
    bit                quiet    = 1'b0;

    int rx_stall = 0;
    int rx_draw;

    always #5 aclk = ~aclk;

    bitmap_slot_pool_allocator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bspa_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (fail_count),
        .outstanding (outstanding)
    );

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 10);
    endfunction

    // Result side: random stall before each beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end else if (m_tvalid && m_tready) begin
            rx_draw = draw_wait();
            if (rx_draw > 0) begin
                m_tready <= 1'b0;
                rx_stall <= rx_draw;
            end
        end else if (!m_tready) begin
            if (rx_stall > 1) begin
                rx_stall <= rx_stall - 1;
            end else begin
                rx_stall <= 0;
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                             input logic irq);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        s_tuser  <= {irq, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stop sending and let every outstanding result come back
    task wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task set_config(input logic [ADDR_W-1:0] base, input logic [SB_W-1:0] sb,
                    input logic [SIU_W-1:0] siu, input logic [POL_W-1:0] pol);
        write_reg(REG_BASE, base);
        write_reg(REG_SLOT_BYTES, CFG_DATA_W'(sb));
        write_reg(REG_SLOTS_IN_USE, CFG_DATA_W'(siu));
        write_reg(REG_POLICY, CFG_DATA_W'(pol));
        cfg_valid <= 1'b0;
        cur_base = base;
        cur_sb   = sb;
        cur_siu  = siu;
    endtask

    // One random request, mostly allocs and well-formed frees
    task automatic random_item(input int alloc_pct);
        int unsigned     n;
        int unsigned     roll;
        logic [31:0]     addr;
        logic [CMD_W-1:0] cmd;
        n    = (cur_siu > DEF_POOL_SLOTS) ? DEF_POOL_SLOTS : cur_siu;
        addr = $urandom;
        cmd  = CMD_FREE;
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct) begin
            cmd = CMD_ALLOC;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                if (n > 0 && cur_sb > 0)
                    addr = cur_base + $urandom_range(0, n - 1) * cur_sb;
            end else if (roll < 82) begin
                if (n > 0 && cur_sb > 1)
                    addr = cur_base + $urandom_range(0, n - 1) * cur_sb
                         + $urandom_range(1, cur_sb - 1);
            end else if (roll < 86) begin
                addr = cur_base + n * cur_sb + $urandom_range(0, 3) * cur_sb;
            end else if (roll < 90) begin
                addr = cur_base - $urandom_range(1, 64);
            end else if (roll < 94) begin
                addr = $urandom;
            end else if (roll < 97) begin
                cmd = CMD_STATS;
            end else begin
                cmd = CMD_UNUSED;
            end
        end
        send_item(cmd, addr, 1'($urandom_range(0, 1)));
    endtask

    // Run limit
    initial begin
        #3_000_000;
        $display("tb_top failed");
        $finish;
    end

    initial begin
        int          sent;
        int          phase;
        int          len;
        int          alloc_pct;
        logic [31:0] nbase;
        logic [12:0] nsb;
        logic [6:0]  nsiu;
        logic [1:0]  npol;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: base 0, 32-byte slots, 64 slots, drop
        send_item(CMD_ALLOC, 32'h0, 1'b0);
        send_item(CMD_ALLOC, 32'hFFFF_FFFF, 1'b0);
        send_item(CMD_ALLOC, 32'h0, 1'b1);
        send_item(CMD_FREE, 32'h20, 1'b0);
        send_item(CMD_FREE, 32'h21, 1'b0);          // misaligned
        send_item(CMD_FREE, 32'h800, 1'b0);         // first byte past the pool
        send_item(CMD_FREE, 32'hFFFF_FFFF, 1'b0);
        send_item(CMD_FREE, 32'hA0, 1'b0);          // slot not busy
        send_item(CMD_STATS, 32'h0, 1'b1);
        send_item(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1);
        send_item(CMD_FREE, 32'h7E0, 1'b1);         // last slot, interrupt flag ignored

        // Two slots: exhaustion under the trap, fallback and reserved policies
        wait_drain();
        set_config(32'h0, 13'd32, 7'd2, POL_TRAP);
        send_item(CMD_ALLOC, 32'h0, 1'b0);
        send_item(CMD_ALLOC, 32'h0, 1'b0);
        send_item(CMD_ALLOC, 32'h0, 1'b1);
        wait_drain();
        set_config(32'h0, 13'd32, 7'd2, POL_FALLBACK);
        send_item(CMD_ALLOC, 32'h0, 1'b0);
        wait_drain();
        set_config(32'h0, 13'd32, 7'd2, POL_RESERVED);
        send_item(CMD_ALLOC, 32'h0, 1'b0);

        // No managed slots
        wait_drain();
        set_config(32'h0, 13'd32, 7'd0, POL_TRAP);
        send_item(CMD_ALLOC, 32'h0, 1'b0);
        send_item(CMD_FREE, 32'h0, 1'b0);

        // Zero slot size
        wait_drain();
        set_config(32'h1000, 13'd0, 7'd4, POL_DROP);
        send_item(CMD_ALLOC, 32'h0, 1'b0);
        send_item(CMD_FREE, 32'h1000, 1'b0);

        // Base near the top, widest slots, count above capacity
        wait_drain();
        set_config(32'hFFFF_FFF0, 13'h1FFF, 7'h7F, POL_FALLBACK);
        send_item(CMD_ALLOC, 32'h0, 1'b0);          // address wraps
        send_item(CMD_FREE, 32'hFFFF_FFF0, 1'b0);
        send_item(CMD_FREE, 32'h0, 1'b0);           // below base
        send_item(CMD_FREE, 32'hFFFF_FFF1, 1'b0);

        // One slot
        wait_drain();
        set_config(32'h0, 13'd4096, 7'd1, POL_TRAP);
        send_item(CMD_ALLOC, 32'h0, 1'b0);
        send_item(CMD_ALLOC, 32'h0, 1'b0);

        // Random phases, each with fresh register settings
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0: nbase = 32'h0;
                1: nbase = $urandom;
                2: nbase = 32'hFFFF_0000 | $urandom_range(0, 16'hFFFF);
                default: nbase = $urandom & 32'h000F_FFF0;
            endcase
            case ($urandom_range(0, 9))
                0: nsb = 13'd0;
                1: nsb = 13'h1FFF;
                2: nsb = 13'($urandom_range(1, 3));
                3: nsb = 13'($urandom_range(0, 8191));
                default: nsb = 13'($urandom_range(4, 4096));
            endcase
            case ($urandom_range(0, 9))
                0: nsiu = 7'd0;
                1: nsiu = 7'd64;
                2: nsiu = 7'($urandom_range(65, 127));
                3: nsiu = 7'($urandom_range(17, 63));
                default: nsiu = 7'($urandom_range(1, 16));
            endcase
            npol      = 2'($urandom_range(0, 3));
            alloc_pct = $urandom_range(30, 75);
            len       = $urandom_range(40, 120);

            wait_drain();
            set_config(nbase, nsb, nsiu, npol);
            quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++) begin
                // hold off mid-phase until the pipeline is empty
                if (i == len / 2 && (phase == 0 || $urandom_range(0, 2) == 0))
                    wait_drain();
                random_item(alloc_pct);
            end
            sent += len;
            phase++;
        end

        wait_drain();
        repeat (40) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
